### rtl/segment_sketch_split_router_unit_defines.svh
// Assertion macros shared by the segment sketch split router files.
`ifndef SEGMENT_SKETCH_SPLIT_ROUTER_UNIT_DEFINES_SVH
`define SEGMENT_SKETCH_SPLIT_ROUTER_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SSR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define SSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ssr_pkg.sv
// Shared constants and types of the segment sketch split router.
package ssr_pkg;
  localparam int SEG_MAX = 256;
  localparam int CNT_W   = $clog2(SEG_MAX + 1);
  localparam int SUM_W   = 16 + $clog2(SEG_MAX);
  localparam int SQ_W    = 32 + $clog2(SEG_MAX);
  localparam int STEP_W  = $clog2(SQ_W + 1);
  localparam int ROOT_STEPS = 16;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  localparam logic CFG_SPLIT_BY_STDEV  = 1'b0;
  localparam logic CFG_SPLIT_THRESHOLD = 1'b1;

  // One job from the front part to the back part.
  typedef struct packed {
    logic                    clr;
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sq;
    logic [CNT_W-1:0]        cnt;
  } job_t;

  // Queue head toward the back part.
  typedef struct packed {
    logic valid;
    job_t job;
  } head_t;
endpackage

### rtl/segment_sketch_split_router_unit.sv
// Top level of the segment sketch split router.
// Samples are taken one per cycle into running sums while the queue has room; a
// segment end or clear command is queued (two entries) for the back part. A clear
// is done there in the pop; a segment goes from queue pop to result through the
// pop, a 40-step bit-serial divider for mean and mean square, the mean, multiply
// and variance states that floor the mean, square it and subtract, a 16-step
// square root, then the done state, which waits while the previous result is
// stalled and then widens the envelope and loads the output register. Samples of
// the next segment keep flowing while the back part works; the input stalls only
// when both queue entries are waiting.
module segment_sketch_split_router_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_cmd,
  input  logic signed [15:0]  in_sample,
  input  logic                in_last_sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  out_seg_mean,
  output logic [14:0]         out_seg_stdev,
  output logic                out_route_left,
  output logic signed [15:0]  out_env_max_mean,
  output logic signed [15:0]  out_env_min_mean,
  output logic [14:0]         out_env_max_stdev,
  output logic [14:0]         out_env_min_stdev,
  output logic signed [15:0]  out_mean_split_value,
  output logic [14:0]         out_stdev_split_value
);
  import ssr_pkg::*;

  head_t head;
  logic  pop;

  ssr_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_cmd, .in_sample, .in_last_sample,
    .head, .pop
  );

  ssr_back u_back (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata, .head, .pop,
    .out_valid, .out_stall, .out_seg_mean, .out_seg_stdev, .out_route_left,
    .out_env_max_mean, .out_env_min_mean, .out_env_max_stdev, .out_env_min_stdev,
    .out_mean_split_value, .out_stdev_split_value
  );
endmodule

### rtl/ssr_front.sv
// Front part: accumulates segment sums and queues segment-end and clear jobs.
module ssr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_cmd,
  input  logic signed [15:0]  in_sample,
  input  logic                in_last_sample,
  output ssr_pkg::head_t      head,
  input  logic                pop
);
  import ssr_pkg::*;
  `include "segment_sketch_split_router_unit_defines.svh"

  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [SQ_W-1:0]         sq_r, sq_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  job_t                    q_r [2];
  logic                    wp_r, rp_r;
  logic [1:0]              fill_r, fill_nxt;
  logic                    acc, push;
  logic signed [SUM_W-1:0] sum_add;
  logic [SQ_W-1:0]         sq_add;
  logic [CNT_W-1:0]        cnt_add;
  logic signed [31:0]      prod;
  job_t                    push_job;

  assign in_stall = (fill_r == 2'd2);
  assign acc      = in_valid && !in_stall;
  assign prod     = in_sample * in_sample;

  // Add the sample unless the segment is already full
  always_comb begin
    sum_add = sum_r;
    sq_add  = sq_r;
    cnt_add = cnt_r;
    if (cnt_r < CNT_W'(SEG_MAX)) begin
      sum_add = sum_r + SUM_W'(in_sample);
      sq_add  = sq_r + SQ_W'(unsigned'(prod));
      cnt_add = cnt_r + 1'b1;
    end
  end

  always_comb begin
    sum_nxt = sum_r;
    sq_nxt  = sq_r;
    cnt_nxt = cnt_r;
    push    = 1'b0;
    push_job.clr = (in_cmd == CMD_CLEAR);
    push_job.sum = sum_add;
    push_job.sq  = sq_add;
    push_job.cnt = cnt_add;
    if (acc) begin
      if (in_cmd == CMD_CLEAR) begin
        push = 1'b1;
      end else if (in_last_sample) begin
        push    = 1'b1;
        sum_nxt = '0;
        sq_nxt  = '0;
        cnt_nxt = '0;
      end else begin
        sum_nxt = sum_add;
        sq_nxt  = sq_add;
        cnt_nxt = cnt_add;
      end
    end
  end

  assign fill_nxt = fill_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      sq_r   <= '0;
      cnt_r  <= '0;
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= '0;
    end else begin
      sum_r  <= sum_nxt;
      sq_r   <= sq_nxt;
      cnt_r  <= cnt_nxt;
      fill_r <= fill_nxt;
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
    end
  end

  // Hold queued jobs
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= push_job;
  end

  assign head.valid = (fill_r != 2'd0);
  assign head.job   = q_r[rp_r];

  `SSR_ASSERT_NOW(a_fill_bound, 1'b1, fill_r != 2'd3, "queue fill out of range")
  `SSR_ASSERT_NOW(a_pop_nonempty, pop, fill_r != 2'd0, "pop from empty queue")
  `SSR_ASSERT_NOW(a_push_room, push, fill_r != 2'd2, "push into full queue")
endmodule

### rtl/ssr_back.sv
// Back part: divides, takes the root, widens or clears the envelope and drives results.
module ssr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_wdata,
  input  ssr_pkg::head_t      head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  out_seg_mean,
  output logic [14:0]         out_seg_stdev,
  output logic                out_route_left,
  output logic signed [15:0]  out_env_max_mean,
  output logic signed [15:0]  out_env_min_mean,
  output logic [14:0]         out_env_max_stdev,
  output logic [14:0]         out_env_min_stdev,
  output logic signed [15:0]  out_mean_split_value,
  output logic [14:0]         out_stdev_split_value
);
  import ssr_pkg::*;
  `include "segment_sketch_split_router_unit_defines.svh"

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_MEAN = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_VAR  = 3'd4;
  localparam logic [2:0] ST_ROOT = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0]              state_r;
  logic                    by_stdev_r;
  logic signed [15:0]      thr_r;
  logic signed [15:0]      max_mean_r, min_mean_r;
  logic [14:0]             max_sd_r, min_sd_r;
  logic                    neg_r;
  logic [SQ_W-1:0]         na_r, nb_r;
  logic [CNT_W-1:0]        ra_r, rb_r, d_r;
  logic [STEP_W-1:0]       step_r;
  logic signed [15:0]      mean_r;
  logic [30:0]             q2_r;
  logic [31:0]             msq_r;
  logic [31:0]             v_r;
  logic [15:0]             root_r;
  logic [18:0]             rem_r;
  logic                    out_valid_r;

  logic [CNT_W:0]          ta, tb;
  logic                    ga, gb;
  logic [SUM_W:0]          mag;
  logic signed [SUM_W:0]   mean_full;
  logic signed [32:0]      var_s;
  logic [18:0]             rt, trial;
  logic                    gr;
  logic [14:0]             sd;
  logic signed [15:0]      nmax_mean, nmin_mean;
  logic [14:0]             nmax_sd, nmin_sd;
  logic signed [16:0]      ind, mid_m;
  logic [15:0]             mid_s;
  logic                    out_free;

  // One restoring divide step on both numerators
  assign ta = {ra_r, na_r[SQ_W-1]};
  assign tb = {rb_r, nb_r[SQ_W-1]};
  assign ga = (ta >= {1'b0, d_r});
  assign gb = (tb >= {1'b0, d_r});

  // Floor the signed mean from magnitude quotient and remainder
  assign mag       = {1'b0, na_r[SUM_W-1:0]} + (SUM_W+1)'(neg_r && (ra_r != '0));
  assign mean_full = neg_r ? -$signed(mag) : $signed(mag);
  assign var_s     = $signed({2'b00, q2_r}) - $signed({1'b0, msq_r});

  // One root digit per cycle
  assign rt    = {rem_r[16:0], v_r[31:30]};
  assign trial = {1'b0, root_r, 2'b01};
  assign gr    = (rt >= trial);

  assign sd        = root_r[15] ? 15'h7fff : root_r[14:0];
  assign nmax_mean = (mean_r > max_mean_r) ? mean_r : max_mean_r;
  assign nmin_mean = (mean_r < min_mean_r) ? mean_r : min_mean_r;
  assign nmax_sd   = (sd > max_sd_r) ? sd : max_sd_r;
  assign nmin_sd   = (sd < min_sd_r) ? sd : min_sd_r;
  assign ind       = by_stdev_r ? $signed({2'b00, sd}) : 17'(mean_r);
  assign mid_m     = 17'(nmax_mean) + 17'(nmin_mean);
  assign mid_s     = {1'b0, nmax_sd} + {1'b0, nmin_sd};
  assign out_free  = !out_valid_r || !out_stall;

  assign pop       = (state_r == ST_IDLE) && head.valid;
  assign out_valid = out_valid_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      by_stdev_r <= 1'b0;
      thr_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SPLIT_BY_STDEV:  by_stdev_r <= cfg_wdata[0];
        CFG_SPLIT_THRESHOLD: thr_r      <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Sequencer and envelope
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      max_mean_r  <= 16'sh8000;
      min_mean_r  <= 16'sh7fff;
      max_sd_r    <= '0;
      min_sd_r    <= 15'h7fff;
    end else begin
      if (out_valid_r && !out_stall && state_r != ST_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (head.valid) begin
            if (head.job.clr) begin
              max_mean_r <= 16'sh8000;
              min_mean_r <= 16'sh7fff;
              max_sd_r   <= '0;
              min_sd_r   <= 15'h7fff;
            end else begin
              state_r <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (step_r == STEP_W'(SQ_W - 1)) state_r <= ST_MEAN;
        end
        ST_MEAN: state_r <= ST_MUL;
        ST_MUL:  state_r <= ST_VAR;
        ST_VAR:  state_r <= ST_ROOT;
        ST_ROOT: begin
          if (step_r == STEP_W'(ROOT_STEPS - 1)) state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            max_mean_r  <= nmax_mean;
            min_mean_r  <= nmin_mean;
            max_sd_r    <= nmax_sd;
            min_sd_r    <= nmin_sd;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        neg_r  <= head.job.sum[SUM_W-1];
        na_r   <= SQ_W'(unsigned'(head.job.sum[SUM_W-1] ? -head.job.sum : head.job.sum));
        nb_r   <= head.job.sq;
        d_r    <= head.job.cnt;
        ra_r   <= '0;
        rb_r   <= '0;
        step_r <= '0;
      end
      ST_DIV: begin
        ra_r   <= ga ? CNT_W'(ta - {1'b0, d_r}) : ta[CNT_W-1:0];
        rb_r   <= gb ? CNT_W'(tb - {1'b0, d_r}) : tb[CNT_W-1:0];
        na_r   <= {na_r[SQ_W-2:0], ga};
        nb_r   <= {nb_r[SQ_W-2:0], gb};
        step_r <= step_r + 1'b1;
      end
      ST_MEAN: begin
        mean_r <= mean_full[15:0];
        q2_r   <= nb_r[30:0];
      end
      ST_MUL: msq_r <= unsigned'(32'(mean_r) * 32'(mean_r));
      ST_VAR: begin
        v_r    <= var_s[32] ? '0 : var_s[31:0];
        rem_r  <= '0;
        root_r <= '0;
        step_r <= '0;
      end
      ST_ROOT: begin
        rem_r  <= gr ? (rt - trial) : rt;
        root_r <= {root_r[14:0], gr};
        v_r    <= {v_r[29:0], 2'b00};
        step_r <= step_r + 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          out_seg_mean          <= mean_r;
          out_seg_stdev         <= sd;
          out_route_left        <= (ind < 17'(thr_r));
          out_env_max_mean      <= nmax_mean;
          out_env_min_mean      <= nmin_mean;
          out_env_max_stdev     <= nmax_sd;
          out_env_min_stdev     <= nmin_sd;
          out_mean_split_value  <= mid_m[16:1];
          out_stdev_split_value <= mid_s[15:1];
        end
      end
      default: ;
    endcase
  end

  `SSR_ASSERT_NEXT(a_rise_from_done, !out_valid_r && state_r != ST_DONE, !out_valid_r,
    "result raised outside of segment end")
  `SSR_ASSERT_NOW(a_env_order, out_valid_r, out_env_min_mean <= out_env_max_mean,
    "mean envelope inverted")
  `SSR_ASSERT_NOW(a_stdev_order, out_valid_r, out_env_min_stdev <= out_env_max_stdev,
    "stdev envelope inverted")
endmodule
